### rtl/ssr_pkg.sv
// Shared types, constants and helpers for the stream search-and-replace block.
// No dependencies; every other file in this folder imports this package.
package ssr_pkg;

    localparam int REG_BYTES               = 8;
    localparam int DEFAULT_MAX_PATTERN     = 8;
    localparam int DEFAULT_MAX_REPLACEMENT = 8;

    localparam logic [7:0] NEWLINE = 8'd10;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Per-cycle commands for the cell chain.
    typedef struct packed {
        logic shift;
        logic load;
        logic pat_load;
    } cell_ctrl_t;

    // A length of zero counts as one; anything above the cap counts as the cap.
    function automatic logic [3:0] clamp_len(input logic [3:0] value, input logic [3:0] cap);
        logic [3:0] result;
        if (value == 4'd0) begin
            result = 4'd1;
        end else if (value > cap) begin
            result = cap;
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

### rtl/ssr_cell.sv
// One cell of the match window: a held text byte and the pattern byte at its place.
// Depends on ssr_pkg for the control struct.
module ssr_cell
    import ssr_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] load_byte,
    input  logic [7:0] right_byte,
    input  logic [7:0] pat_byte,
    output logic [7:0] data_byte,
    output logic       eq
);

    logic [7:0] data_reg;
    logic [7:0] pat_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= load_byte;
        end else if (ctrl.shift) begin
            data_reg <= right_byte;
        end
        if (ctrl.pat_load) begin
            pat_reg <= pat_byte;
        end
    end

    assign data_byte = data_reg;
    assign eq        = (data_reg == pat_reg);

endmodule

### rtl/ssr_window.sv
// Chain of match cells that holds the undecided bytes and shifts them toward the head.
// Depends on ssr_pkg and ssr_cell.
module ssr_window
    import ssr_pkg::*;
#(
    parameter int NUM_CELLS = REG_BYTES,
    parameter int CNT_W     = $clog2(NUM_CELLS + 1)
) (
    input  logic                   aclk,
    input  cell_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic [7:0]             in_byte,
    input  logic [8*NUM_CELLS-1:0] pat_bytes,
    output logic [7:0]             head_byte,
    output logic                   all_ok
);

    logic [7:0]           cell_data [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_eq;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        cell_ctrl_t cc;
        logic [7:0] right;

        always_comb begin
            cc.shift    = ctrl.shift;
            cc.pat_load = ctrl.pat_load;
            cc.load     = ctrl.load && (count == CNT_W'(i));
        end

        if (i == NUM_CELLS - 1) begin : g_tail
            assign right = cell_data[i];
        end else begin : g_body
            assign right = cell_data[i+1];
        end

        ssr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cc),
            .load_byte  (in_byte),
            .right_byte (right),
            .pat_byte   (pat_bytes[8*i +: 8]),
            .data_byte  (cell_data[i]),
            .eq         (cell_eq[i])
        );
    end

    // The held bytes form a prefix of the pattern when every occupied cell agrees.
    always_comb begin
        all_ok = 1'b1;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (CNT_W'(i) < count) begin
                all_ok = all_ok & cell_eq[i];
            end
        end
    end

    assign head_byte = cell_data[0];

endmodule

### rtl/stream_search_replace.sv
// Top level of the stream search-and-replace block: configuration registers,
// sequencer and output stage. Depends on ssr_pkg and ssr_window.

// This block replaces every leftmost, non-overlapping occurrence of the search
// pattern in a byte stream with the replacement text; inserted text is never
// searched again and no match spans a newline. Bytes that could still begin a
// match are held in a chain of cells until a match or a mismatch decides them,
// so a transaction on the input may produce no output at once and several bytes
// later. Each input transaction is worked on alone: the block takes it, then
// decides or releases bytes one by one; in each step the window either shifts its
// head byte out or is compared in full against the active pattern. A completed
// match emits the replacement text. A newline or an end-of-stream transaction
// releases the held bytes and then a newline, the end of stream only when it
// closes a line with content. Output back-pressure can stall any step. The final
// byte caused by an input transaction carries last_of_run; it is kept one step
// back in a pending register so the flag can be set once the run is known to be
// over. Configuration is to be written only while the block is idle; a new
// pattern is taken into the cells only when a byte arrives with nothing held.
module stream_search_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = DEFAULT_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEFAULT_MAX_REPLACEMENT
) (
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      cfg_wen,
    input  logic [1:0] cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,

    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    // Effective limits: the registers hold at most eight bytes.
    localparam int PAT_CAP = (MAX_PATTERN < 1) ? 1 :
                             ((MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES);
    localparam int REP_CAP = (MAX_REPLACEMENT < 1) ? 1 :
                             ((MAX_REPLACEMENT < REG_BYTES) ? MAX_REPLACEMENT : REG_BYTES);
    localparam int CNT_W   = $clog2(PAT_CAP + 1);
    localparam int RIDX_W  = $clog2(REG_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_TAIL,
        ST_FIN
    } state_t;

    // Configuration registers.
    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [63:0] replacement_bytes_reg;
    logic [3:0]  replacement_length_reg;

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              line_reg, line_next;
    logic              tail_nl_reg, tail_nl_next;
    logic [3:0]        plen_reg, plen_next;
    logic [RIDX_W-1:0] rep_idx_reg, rep_idx_next;

    // Pending byte and output register.
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_payload_reg, m_payload_next;

    cell_ctrl_t win_ctrl;
    logic [7:0] head_byte;
    logic       all_ok;

    logic       out_free;
    logic       stall;
    logic       emit_req;
    logic       finish_req;
    logic [7:0] emit_byte;
    logic [3:0] rlen;

    ssr_window #(
        .NUM_CELLS (PAT_CAP),
        .CNT_W     (CNT_W)
    ) u_window (
        .aclk      (aclk),
        .ctrl      (win_ctrl),
        .count     (count_reg),
        .in_byte   (s_payload.data_byte),
        .pat_bytes (pattern_bytes_reg[8*PAT_CAP-1:0]),
        .head_byte (head_byte),
        .all_ok    (all_ok)
    );

    assign out_free = !m_valid_reg || m_ready;
    // A new byte or the end of a run pushes the pending byte out, which needs room.
    assign stall    = pend_valid_reg && !out_free;
    assign rlen     = clamp_len(replacement_length_reg, 4'(REP_CAP));
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        line_next       = line_reg;
        tail_nl_next    = tail_nl_reg;
        plen_next       = plen_reg;
        rep_idx_next    = rep_idx_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        win_ctrl        = '0;
        emit_req        = 1'b0;
        finish_req      = 1'b0;
        emit_byte       = head_byte;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.end_of_stream) begin
                        // Held bytes count as line content.
                        tail_nl_next = line_reg || (count_reg != '0);
                        line_next    = 1'b0;
                        state_next   = ST_FLUSH;
                    end else if (s_payload.data_byte == NEWLINE) begin
                        tail_nl_next = 1'b1;
                        line_next    = 1'b0;
                        state_next   = ST_FLUSH;
                    end else begin
                        line_next = 1'b1;
                        if (count_reg == '0) begin
                            win_ctrl.pat_load = 1'b1;
                            plen_next = clamp_len(pattern_length_reg, 4'(PAT_CAP));
                        end
                        win_ctrl.load = 1'b1;
                        count_next    = count_reg + 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (all_ok) begin
                        if (4'(count_reg) == plen_reg) begin
                            count_next   = '0;
                            rep_idx_next = '0;
                            state_next   = ST_REPL;
                        end else begin
                            // Remaining bytes are a proper prefix; keep them held.
                            finish_req = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        emit_req       = 1'b1;
                        win_ctrl.shift = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
            end
            ST_REPL: begin
                if (!stall) begin
                    emit_req     = 1'b1;
                    emit_byte    = replacement_bytes_reg[8*rep_idx_reg +: 8];
                    rep_idx_next = rep_idx_reg + 1'b1;
                    if ({1'b0, rep_idx_reg} == rlen - 4'd1) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stall) begin
                    if (count_reg != '0) begin
                        emit_req       = 1'b1;
                        win_ctrl.shift = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end else if (tail_nl_reg) begin
                        state_next = ST_TAIL;
                    end else begin
                        finish_req = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (!stall) begin
                    emit_req   = 1'b1;
                    emit_byte  = NEWLINE;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!stall) begin
                    finish_req = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_req) begin
            if (pend_valid_reg) begin
                m_valid_next   = 1'b1;
                m_payload_next = '{out_byte: pend_byte_reg, last_of_run: 1'b0};
            end
            pend_byte_next  = emit_byte;
            pend_valid_next = 1'b1;
        end
        if (finish_req && pend_valid_reg) begin
            m_valid_next    = 1'b1;
            m_payload_next  = '{out_byte: pend_byte_reg, last_of_run: 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= ST_IDLE;
            count_reg              <= '0;
            line_reg               <= 1'b0;
            tail_nl_reg            <= 1'b0;
            plen_reg               <= 4'd1;
            rep_idx_reg            <= '0;
            pend_valid_reg         <= 1'b0;
            m_valid_reg            <= 1'b0;
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= 4'd1;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            line_reg       <= line_next;
            tail_nl_reg    <= tail_nl_next;
            plen_reg       <= plen_next;
            rep_idx_reg    <= rep_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wen) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_wdata;
                    CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_wdata[3:0];
                    CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_wdata;
                    CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_wdata[3:0];
                    default:                pattern_length_reg     <= pattern_length_reg;
                endcase
            end
        end
        pend_byte_reg <= pend_byte_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for stream_search_replace: random and directed text
// streams, a predictor of the rewritten text, and a scoreboard on the output.
// Depends on ssr_pkg and the stream_search_replace RTL.
`timescale 1ns / 100ps

module testbench;
    import ssr_pkg::*;

    // Random text items spread over three idle modes of four settings each.
    localparam int RANDOM_ITEMS  = 324;
    localparam int SEGMENTS      = 12;
    // Quiet cycles after the last output before config is touched again. A
    // byte that decides nothing keeps the block busy without any output.
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_payload;

    stream_search_replace dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    // Text waiting to be sent and rewritten text waiting to come out.
    in_item_t  pending_items [$];
    out_item_t expected_text [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    // Predictor state: our copy of the registers and of the match window.
    logic [63:0] pattern_reg         = '0;
    logic [3:0]  pattern_len_reg     = 4'd1;
    logic [63:0] replacement_reg     = '0;
    logic [3:0]  replacement_len_reg = 4'd1;
    logic [7:0]  held_text [0:7];
    int          held_count          = 0;
    logic        line_open           = 1'b0;
    logic [63:0] active_pattern      = '0;
    int          active_len          = 1;

    // A length of zero acts as one and anything past the limit acts as the limit.
    function automatic int effective_length(input logic [3:0] value, input int limit);
        int cap;
        cap = (limit < 8) ? limit : 8;
        if (cap < 1) begin
            cap = 1;
        end
        if (value == 4'd0) begin
            return 1;
        end
        if (int'(value) > cap) begin
            return cap;
        end
        return int'(value);
    endfunction

    // Works out the output bytes caused by one accepted input transaction and
    // queues them, the final one flagged as the last of its run.
    function automatic void predict_rewrite(input in_item_t item);
        logic [7:0] window [0:8];
        logic [7:0] run_bytes [0:23];
        out_item_t  result;
        int         run_len;
        int         total;
        int         pos;
        int         span;
        int         repl_len;
        int         i;
        logic       hit;
        logic       waiting;
        run_len = 0;
        if (item.end_of_stream || item.data_byte == NEWLINE) begin
            // Both release the held bytes untouched; end of stream only ends
            // the line with a newline when the line had content.
            if (item.end_of_stream && held_count != 0) begin
                line_open = 1'b1;
            end
            for (i = 0; i < held_count; i++) begin
                run_bytes[run_len] = held_text[i];
                run_len++;
            end
            held_count = 0;
            if (!item.end_of_stream || line_open) begin
                run_bytes[run_len] = NEWLINE;
                run_len++;
            end
            line_open = 1'b0;
        end else begin
            line_open = 1'b1;
            // A new pattern is only picked up when nothing is held.
            if (held_count == 0) begin
                active_pattern = pattern_reg;
                active_len     = effective_length(pattern_len_reg, DEFAULT_MAX_PATTERN);
            end
            repl_len = effective_length(replacement_len_reg, DEFAULT_MAX_REPLACEMENT);
            for (i = 0; i < held_count; i++) begin
                window[i] = held_text[i];
            end
            window[held_count] = item.data_byte;
            total   = held_count + 1;
            pos     = 0;
            waiting = 1'b0;
            while (pos < total && !waiting) begin
                span = (total - pos < active_len) ? total - pos : active_len;
                hit  = 1'b1;
                for (i = 0; i < span; i++) begin
                    if (window[pos + i] != active_pattern[8 * i +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit && total - pos >= active_len) begin
                    for (i = 0; i < repl_len; i++) begin
                        run_bytes[run_len] = replacement_reg[8 * i +: 8];
                        run_len++;
                    end
                    pos += active_len;
                end else if (hit) begin
                    // The tail is still a prefix of the pattern: keep holding it.
                    waiting = 1'b1;
                end else begin
                    run_bytes[run_len] = window[pos];
                    run_len++;
                    pos++;
                end
            end
            held_count = total - pos;
            for (i = 0; i < held_count; i++) begin
                held_text[i] = window[pos + i];
            end
        end
        for (i = 0; i < run_len; i++) begin
            result.out_byte    = run_bytes[i];
            result.last_of_run = (i == run_len - 1);
            expected_text.push_back(result);
        end
    endfunction

    // Driver: offers the next pending item, holding it until it is taken. The
    // predictor runs at the edge where the input transaction completes, with
    // the payload as it stood before this edge's updates.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_rewrite(s_payload);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                        $urandom_range(0, 99) >= send_idle_pct) begin
                    s_payload <= pending_items.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each output transaction with the oldest expected byte
    // and stalls the output at random.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    if (error_count < 10) begin
                        $display("cycle %0d: unexpected output byte %02h last %0b",
                                 cycle_count, m_payload.out_byte, m_payload.last_of_run);
                    end
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_payload.out_byte !== want.out_byte ||
                            m_payload.last_of_run !== want.last_of_run) begin
                        if (error_count < 10) begin
                            $display("cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                     cycle_count, want.out_byte, want.last_of_run,
                                     m_payload.out_byte, m_payload.last_of_run);
                        end
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Guards against a hang anywhere in the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void push_item(input logic [7:0] value, input logic eos);
        in_item_t item;
        item.data_byte     = value;
        item.end_of_stream = eos;
        pending_items.push_back(item);
    endfunction

    // Queues the first count bytes of a register-style text word.
    function automatic void push_text(input logic [63:0] text, input int count);
        int i;
        for (i = 0; i < count; i++) begin
            push_item(text[8 * i +: 8], 1'b0);
        end
    endfunction

    // One piece of random text, biased toward whole and broken copies of the
    // current pattern so that the match logic is exercised in depth.
    // Returns the number of items queued.
    function automatic int add_random_chunk();
        int kind;
        int plen;
        int cut;
        plen = effective_length(pattern_len_reg, DEFAULT_MAX_PATTERN);
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            push_text(pattern_reg, plen);
            return plen;
        end else if (kind < 50) begin
            cut = $urandom_range(1, plen);
            push_text(pattern_reg, cut - 1);
            push_item(8'($urandom_range(0, 255)), 1'b0);
            return cut;
        end else if (kind < 60) begin
            push_item(NEWLINE, 1'b0);
        end else if (kind < 66) begin
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end else if (kind < 80) begin
            push_item(pattern_reg[8 * $urandom_range(0, plen - 1) +: 8], 1'b0);
        end else begin
            push_item(8'($urandom_range(0, 255)), 1'b0);
        end
        return 1;
    endfunction

    // Pattern or replacement text: a two-letter alphabet with the odd newline
    // gives overlapping and self-similar patterns; the rest covers all bits.
    function automatic logic [63:0] random_text_word();
        logic [63:0] word;
        int          i;
        int          pick;
        case ($urandom_range(0, 5))
            0: word = '1;
            1: word = '0;
            2: word = {$urandom, $urandom};
            default: begin
                for (i = 0; i < 8; i++) begin
                    pick = $urandom_range(0, 19);
                    word[8 * i +: 8] = (pick == 0) ? NEWLINE : ((pick < 10) ? 8'h61 : 8'h62);
                end
            end
        endcase
        return word;
    endfunction

    // Length values including the out-of-range ones, with random upper bits.
    function automatic logic [63:0] random_length_word();
        logic [63:0] word;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: word[3:0] = 4'd0;
            1: word[3:0] = 4'd1;
            2: word[3:0] = 4'd8;
            3: word[3:0] = 4'd15;
            default: word[3:0] = 4'($urandom_range(0, 15));
        endcase
        return word;
    endfunction

    task automatic write_reg(input cfg_reg_t index, input logic [63:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_PATTERN_BYTES:      pattern_reg         = value;
            CFG_PATTERN_LENGTH:     pattern_len_reg     = value[3:0];
            CFG_REPLACEMENT_BYTES:  replacement_reg     = value;
            CFG_REPLACEMENT_LENGTH: replacement_len_reg = value[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] pattern, input logic [63:0] pattern_len,
                             input logic [63:0] replacement,
                             input logic [63:0] replacement_len);
        write_reg(CFG_PATTERN_BYTES, pattern);
        write_reg(CFG_PATTERN_LENGTH, pattern_len);
        write_reg(CFG_REPLACEMENT_BYTES, replacement);
        write_reg(CFG_REPLACEMENT_LENGTH, replacement_len);
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Waits until every queued item is sent and every expected byte has come
    // out, then lets the block finish any silent work. Polling on the falling
    // edge keeps the check clear of the driver's updates.
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (pending_items.size() != 0 || s_valid || expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase;
        int segment;
        int queued;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with a slow sender and a heavily stalled receiver.
        send_idle_pct = 13;
        recv_idle_pct = 77;

        // Reset settings: a one-byte zero pattern replaced by a zero byte.
        push_item(8'h00, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h00, 1'b1);
        drain();

        // "abc" becomes "XY".
        configure(64'h636261, 64'd3, 64'h5958, 64'd2);
        push_text(64'h636261, 3);
        push_text(64'h646261, 3);           // partial match broken by a byte
        push_text(64'h6261, 2);
        push_item(NEWLINE, 1'b0);           // newline releases a partial match
        push_text(64'h63626161, 4);         // leftmost match after a false start
        push_item(8'h61, 1'b0);
        push_item(8'hff, 1'b1);             // end of stream with a byte held
        push_item(8'h00, 1'b1);             // end of stream on an empty line
        drain();

        // Pattern change in the middle of a match: the held "ab" is still
        // decided against "abc", while the new replacement applies at once.
        push_text(64'h6261, 2);
        drain();
        configure(64'h7a7978, 64'd3, '1, 64'd15);
        push_item(8'h63, 1'b0);
        push_text(64'h7a7978, 3);
        push_item(8'h00, 1'b1);
        drain();

        // A pattern holding a newline can never match, and a zero length
        // counts as one.
        configure(64'h620a61, 64'd3, 64'h41, 64'd0);
        push_item(8'h61, 1'b0);
        push_item(NEWLINE, 1'b0);
        push_item(8'h62, 1'b1);
        drain();

        // Random part: three idle modes, several settings each. Segments that
        // end with bytes held leave a pattern change pending for the next.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (segment = 0; segment < SEGMENTS / 3; segment++) begin
                configure(random_text_word(), random_length_word(),
                          random_text_word(), random_length_word());
                queued = 0;
                while (queued < RANDOM_ITEMS / SEGMENTS) begin
                    queued += add_random_chunk();
                end
                drain();
            end
        end

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ssr_pkg.sv
rtl/ssr_cell.sv
rtl/ssr_window.sv
rtl/stream_search_replace.sv
tb/testbench.sv
